@@ rtl/assert_macros.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/hufw_pkg.sv @@
// Types and constants of the Huffman tree-walk decoder.
package hufw_pkg;
	localparam int NODE_COUNT_DEFAULT = 512;
	localparam int IDX_W = 9;
	localparam int SYM_W = 8;
	localparam int BYTE_W = 8;
	localparam int PAD_W = 3;
	localparam int CNT_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_ROOT_NODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_BITS = 1'd1;
	localparam logic OP_NODE_WR = 1'b0;
	localparam logic OP_DATA = 1'b1;
	localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [SYM_W-1:0] sym_t;

	typedef struct packed {
		logic leaf;
		sym_t symbol;
		idx_t left;
		idx_t right;
	} node_t;

	typedef struct packed {
		logic node_wr;
		logic byte_ld;
		logic root_rd;
		logic root_ld;
		logic step;
		logic pending;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic stall;
		logic issued;
		logic bits_done;
		logic root_stale;
		logic flush_done;
		logic hold_v;
	} dp_stat_t;
endpackage

@@ rtl/hufw_ifs.sv @@
// Word channel interfaces: input items, decoded symbols, register writes.
interface hufw_in_if;
	import hufw_pkg::*;
	logic valid;
	logic ready;
	logic opcode;
	idx_t node_index;
	logic is_leaf;
	sym_t leaf_symbol;
	idx_t left_child;
	idx_t right_child;
	logic [BYTE_W-1:0] data_byte;
	logic final_byte;
	modport source(output valid, opcode, node_index, is_leaf, leaf_symbol, left_child,
		right_child, data_byte, final_byte, input ready);
	modport sink(input valid, opcode, node_index, is_leaf, leaf_symbol, left_child,
		right_child, data_byte, final_byte, output ready);
endinterface

interface hufw_out_if;
	import hufw_pkg::*;
	logic valid;
	logic ready;
	sym_t decoded_symbol;
	logic last_of_run;
	logic message_end;
	modport source(output valid, decoded_symbol, last_of_run, message_end, input ready);
	modport sink(input valid, decoded_symbol, last_of_run, message_end, output ready);
endinterface

interface hufw_cfg_if;
	import hufw_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source(output valid, reg_index, wdata, input ready);
	modport sink(input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/hufw_ctrl.sv @@
// Controller FSM: sequences node writes, root fetch, bit steps and flush.
module hufw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_opcode,
	output logic               in_ready,
	input  hufw_pkg::dp_stat_t st,
	output hufw_pkg::dp_cmd_t  cmd
);
	import hufw_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROOT  = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_BIT   = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;
	logic       pending_q;

	always_comb begin
		cmd = '0;
		state_n = state_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_opcode == OP_NODE_WR) begin
						cmd.node_wr = 1'b1;
					end else begin
						cmd.byte_ld = 1'b1;
						state_n = st.root_stale ? S_ROOT : S_BIT;
					end
				end
			end
			S_ROOT: begin
				cmd.root_rd = 1'b1;
				state_n = S_LOAD;
			end
			S_LOAD: begin
				cmd.root_ld = 1'b1;
				state_n = S_BIT;
			end
			S_BIT: begin
				if (st.bits_done && !pending_q) begin
					state_n = S_FLUSH;
				end else begin
					cmd.step = 1'b1;
					cmd.pending = pending_q;
				end
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				if (st.flush_done)
					state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pending_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.byte_ld)
				pending_q <= 1'b0;
			else if (cmd.step && !st.stall)
				pending_q <= st.issued;
		end
	end
endmodule

@@ rtl/hufw_dp.sv @@
// Datapath: node table, walk position, bit shifter, symbol hold and output register.
module hufw_dp #(
	parameter int NODE_COUNT = hufw_pkg::NODE_COUNT_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hufw_pkg::dp_cmd_t                 cmd,
	output hufw_pkg::dp_stat_t                st,
	input  hufw_pkg::idx_t                    node_index,
	input  logic                              is_leaf,
	input  hufw_pkg::sym_t                    leaf_symbol,
	input  hufw_pkg::idx_t                    left_child,
	input  hufw_pkg::idx_t                    right_child,
	input  logic [hufw_pkg::BYTE_W-1:0]       data_byte,
	input  logic                              final_byte,
	input  logic                              cfg_valid,
	input  logic [hufw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hufw_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output hufw_pkg::sym_t                    out_symbol,
	output logic                              out_last,
	output logic                              out_end
);
	import hufw_pkg::*;

	localparam int AW = $clog2(NODE_COUNT);

	function automatic logic in_range(input idx_t idx);
		in_range = (32'(idx) < NODE_COUNT);
	endfunction

	node_t          mem [NODE_COUNT];
	node_t          rd_q;
	idx_t           rd_idx_q;
	logic           rd_oor_q;
	node_t          root_c_q;
	idx_t           root_node_q;
	logic [PAD_W-1:0] pad_q;
	logic           root_stale_q;
	logic           at_root_q;
	logic [BYTE_W-1:0] byte_q;
	logic           fin_q;
	logic [CNT_W-1:0] cnt_q;
	logic           hold_v_q;
	sym_t           hold_sym_q;
	logic           out_v_q;
	sym_t           out_sym_q;
	logic           out_last_q;
	logic           out_end_q;

	node_t     wr_node;
	logic      wr_ok;
	logic      mem_re;
	logic [AW-1:0] rd_addr;
	logic      emit;
	logic      stall;
	logic      go;
	logic      at_root_n;
	logic      root_ok;
	logic      cur_ok;
	node_t     cur;
	logic      bit_go;
	logic      issue;
	idx_t      child;
	logic      out_free;
	logic      flush_mv;
	logic      emit_mv;
	logic      cfg_root;

	assign wr_node = '{leaf: is_leaf, symbol: leaf_symbol, left: left_child, right: right_child};
	assign wr_ok = cmd.node_wr && in_range(node_index);

	assign emit = cmd.pending && !rd_oor_q && rd_q.leaf;
	assign stall = emit && hold_v_q && out_v_q && !out_ready;
	assign go = cmd.step && !stall;
	assign at_root_n = cmd.pending ? (rd_oor_q || rd_q.leaf) : at_root_q;
	assign root_ok = in_range(root_node_q) && !root_c_q.leaf;
	assign cur_ok = at_root_n ? root_ok : !rd_q.leaf;
	assign cur = at_root_n ? root_c_q : rd_q;
	assign bit_go = (cnt_q != '0);
	assign issue = cmd.step && bit_go && cur_ok;
	assign child = byte_q[BYTE_W-1] ? cur.right : cur.left;

	assign mem_re = cmd.root_rd || (issue && !stall);
	assign rd_addr = cmd.root_rd ? AW'(root_node_q) : AW'(child);

	assign out_free = !out_v_q || out_ready;
	assign flush_mv = cmd.flush && hold_v_q && out_free;
	assign emit_mv = go && emit && hold_v_q;
	assign cfg_root = cfg_valid && (cfg_index == REG_ROOT_NODE);

	always_ff @(posedge clk) begin
		if (wr_ok)
			mem[AW'(node_index)] <= wr_node;
		if (mem_re)
			rd_q <= mem[rd_addr];
		else if (wr_ok && !at_root_q && (node_index == rd_idx_q))
			rd_q <= wr_node;
	end

	// walk control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_node_q <= '0;
			pad_q <= '0;
			root_stale_q <= 1'b1;
			at_root_q <= 1'b1;
			cnt_q <= '0;
			fin_q <= 1'b0;
			rd_oor_q <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_ROOT_NODE: begin
						root_node_q <= cfg_data[IDX_W-1:0];
						root_stale_q <= 1'b1;
					end
					REG_PAD_BITS: pad_q <= cfg_data[PAD_W-1:0];
					default: ;
				endcase
			end
			if (wr_ok && (node_index == root_node_q))
				root_stale_q <= 1'b0;
			if (cmd.root_ld)
				root_stale_q <= 1'b0;
			if (cmd.byte_ld) begin
				fin_q <= final_byte;
				cnt_q <= final_byte ? (BITS_PER_BYTE - {1'b0, pad_q}) : BITS_PER_BYTE;
			end
			if (go) begin
				// a bit that cannot step (leaf or bad root) sends the walk home
				at_root_q <= issue ? 1'b0 : (bit_go || at_root_n);
				if (bit_go)
					cnt_q <= cnt_q - 4'd1;
				if (issue)
					rd_oor_q <= !in_range(child);
				if (emit)
					hold_v_q <= 1'b1;
			end
			if (flush_mv)
				hold_v_q <= 1'b0;
			if (cmd.flush && st.flush_done && fin_q)
				at_root_q <= 1'b1;
			if (cfg_root)
				at_root_q <= 1'b1;
			if (emit_mv || flush_mv)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.root_ld)
			root_c_q <= rd_q;
		if (wr_ok && (node_index == root_node_q))
			root_c_q <= wr_node;
		if (cmd.byte_ld)
			byte_q <= data_byte;
		else if (go && bit_go)
			byte_q <= {byte_q[BYTE_W-2:0], 1'b0};
		if (go && issue)
			rd_idx_q <= child;
		if (go && emit)
			hold_sym_q <= rd_q.symbol;
		if (emit_mv || flush_mv) begin
			out_sym_q <= hold_sym_q;
			out_last_q <= flush_mv;
			out_end_q <= fin_q;
		end
	end

	always_comb begin
		st = '0;
		st.stall = stall;
		st.issued = issue;
		st.bits_done = !bit_go;
		st.root_stale = root_stale_q;
		st.flush_done = !hold_v_q || out_free;
		st.hold_v = hold_v_q;
	end

	assign out_valid = out_v_q;
	assign out_symbol = out_sym_q;
	assign out_last = out_last_q;
	assign out_end = out_end_q;
endmodule

@@ rtl/huffman_tree_walk_decoder_unit.sv @@
// Huffman tree-walk decoder top level: node table load and MSB-first bit walk.
// Node writes are taken while idle. Data byte: one decoded bit per cycle unless the output stalls
// (8 bits, or 8 - pad_bits on a final byte), set by one dependent node table read per bit;
// accept, last lookup, end check and flush add steps, and a root fetch follows root_node changes.
// Symbols leave through a registered output; the next item is taken while one waits.
// Reset clears root_node, pad_bits and the walk; the node table is not cleared.
`include "assert_macros.svh"
module huffman_tree_walk_decoder_unit #(
	parameter int NODE_COUNT = hufw_pkg::NODE_COUNT_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	hufw_in_if.sink    din,
	hufw_out_if.source dout,
	hufw_cfg_if.sink   cfg
);
	import hufw_pkg::*;

	dp_cmd_t    cmd;
	dp_stat_t   st;
	logic [5:0] cmd_bits;

	assign cfg.ready = 1'b1;

	hufw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_opcode (din.opcode),
		.in_ready  (din.ready),
		.st        (st),
		.cmd       (cmd)
	);

	hufw_dp #(
		.NODE_COUNT (NODE_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.node_index  (din.node_index),
		.is_leaf     (din.is_leaf),
		.leaf_symbol (din.leaf_symbol),
		.left_child  (din.left_child),
		.right_child (din.right_child),
		.data_byte   (din.data_byte),
		.final_byte  (din.final_byte),
		.cfg_valid   (cfg.valid),
		.cfg_index   (cfg.reg_index),
		.cfg_data    (cfg.wdata),
		.out_valid   (dout.valid),
		.out_ready   (dout.ready),
		.out_symbol  (dout.decoded_symbol),
		.out_last    (dout.last_of_run),
		.out_end     (dout.message_end)
	);

	assign cmd_bits = {cmd.node_wr, cmd.byte_ld, cmd.root_rd, cmd.root_ld, cmd.step, cmd.flush};

	`ASSERT_PROP(a_cmd_onehot, clk, arst_n, $onehot0(cmd_bits), "more than one datapath command")
	`ASSERT_PROP(a_ready_no_hold, clk, arst_n, !din.ready || !st.hold_v, "symbol held while idle")
	`ASSERT_PROP(a_stall_out_full, clk, arst_n, !st.stall || dout.valid, "stall with output free")
	`ASSERT_NEXT(a_busy_after_byte, clk, arst_n, cmd.byte_ld, !din.ready, "ready right after byte")
endmodule
